// ===== rtl/wdcv_pkg.sv =====
// Package for the window dominant color vote: widths, constants, codes and shared types.
`timescale 1ns / 1ps

package wdcv_pkg;

  localparam int CHAN_W            = 8;
  localparam int TALLY_W           = 17;
  localparam int VERDICT_W         = 2;
  localparam int MAX_WINDOW_PIXELS = 65536;
  localparam int TALLY_MAX         = (2 ** TALLY_W) - 1;
  localparam int TALLY_CAP_INT     = (MAX_WINDOW_PIXELS < TALLY_MAX) ?
                                     MAX_WINDOW_PIXELS : TALLY_MAX;
  localparam logic [TALLY_W-1:0] TALLY_CAP   = TALLY_W'(TALLY_CAP_INT);
  localparam logic [CHAN_W-1:0]  WHITE_RESET = 8'd245;

  localparam logic [VERDICT_W-1:0] VERDICT_RED   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_GREEN = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BLUE  = 2'd2;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [TALLY_W-1:0]   tally_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic count_en;   // classify the accepted pixel and bump at most one tally
    logic load_out;   // compute the verdict and load the result register
    logic clear;      // zero the tallies
  } wdcv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_pixel; // the pixel on the input carries the end-of-window mark
  } wdcv_status_t;

  // Strict vote: red only when it beats both, green when it beats blue, else blue.
  function automatic verdict_t pick_color(input tally_t r, input tally_t g, input tally_t b);
    verdict_t v;
    if ((r > b) && (r > g)) begin
      v = VERDICT_RED;
    end else if (g > b) begin
      v = VERDICT_GREEN;
    end else begin
      v = VERDICT_BLUE;
    end
    return v;
  endfunction

  function automatic tally_t bump(input tally_t t);
    tally_t n;
    if (t < TALLY_CAP) begin
      n = t + tally_t'(1);
    end else begin
      n = TALLY_CAP;
    end
    return n;
  endfunction

endpackage

// ===== rtl/wdcv_pixel_if.sv =====
// Pixel channel interface: valid, ready and one RGB pixel with its end-of-window mark.
`timescale 1ns / 1ps

interface wdcv_pixel_if;
  import wdcv_pkg::*;

  logic  valid;
  logic  ready;
  chan_t blue;
  chan_t green;
  chan_t red;
  logic  last_pixel;

  modport source (output valid, output blue, output green, output red,
                  output last_pixel, input ready);
  modport sink   (input valid, input blue, input green, input red,
                  input last_pixel, output ready);
endinterface

// ===== rtl/wdcv_result_if.sv =====
// Result channel interface: valid, ready, the verdict and the three window counts.
`timescale 1ns / 1ps

interface wdcv_result_if;
  import wdcv_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  tally_t   red_count;
  tally_t   green_count;
  tally_t   blue_count;

  modport source (output valid, output verdict, output red_count, output green_count,
                  output blue_count, input ready);
  modport sink   (input valid, input verdict, input red_count, input green_count,
                  input blue_count, output ready);
endinterface

// ===== rtl/window_dominant_color_vote.sv =====
// Top level of the window dominant color vote: controller, datapath and channel hookup.
`timescale 1ns / 1ps

// Channel   Direction  Contents
// pixels    in         blue, green, red (8 bit each), last_pixel
// results   out        verdict (2 bit), red_count, green_count, blue_count (17 bit each)
// config    in         white_level_we, white_level_wdata (8 bit)
//
// An ordinary pixel item is taken while the controller is in the count state; the tally
// update is a compare and a 17-bit increment that finish in the cycle the item is
// accepted. A pixel marked last leads into the vote state, in which the verdict is formed
// from the final tallies and loaded into the result register; no pixel is taken in that
// state, which holds while a previous result still waits there to be taken.
// Reset is synchronous and active high: tallies clear, white_level returns to 245.
// A stalled result holds in its register while the next window's pixels keep counting.

module window_dominant_color_vote (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 white_level_we,
  input  wdcv_pkg::chan_t      white_level_wdata,
  wdcv_pixel_if.sink           pixels,
  wdcv_result_if.source        results
);
  import wdcv_pkg::*;

  wdcv_cmd_t    cmd;
  wdcv_status_t status;

  // The controller owns the handshakes; the datapath only sees commands.
  wdcv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath classifies each pixel, keeps the tallies and holds the result item.
  wdcv_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .white_level_we    (white_level_we),
    .white_level_wdata (white_level_wdata),
    .blue              (pixels.blue),
    .green             (pixels.green),
    .red               (pixels.red),
    .last_pixel        (pixels.last_pixel),
    .cmd               (cmd),
    .status            (status),
    .verdict           (results.verdict),
    .red_count         (results.red_count),
    .green_count       (results.green_count),
    .blue_count        (results.blue_count)
  );

endmodule

// ===== rtl/wdcv_datapath.sv =====
// Datapath of the color vote: white level register, three tallies and the result register.
`timescale 1ns / 1ps

module wdcv_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  white_level_we,
  input  wdcv_pkg::chan_t       white_level_wdata,
  input  wdcv_pkg::chan_t       blue,
  input  wdcv_pkg::chan_t       green,
  input  wdcv_pkg::chan_t       red,
  input  logic                  last_pixel,
  input  wdcv_pkg::wdcv_cmd_t   cmd,
  output wdcv_pkg::wdcv_status_t status,
  output wdcv_pkg::verdict_t    verdict,
  output wdcv_pkg::tally_t      red_count,
  output wdcv_pkg::tally_t      green_count,
  output wdcv_pkg::tally_t      blue_count
);
  import wdcv_pkg::*;

  chan_t    white_level;
  tally_t   red_tally, green_tally, blue_tally;
  tally_t   red_tally_next, green_tally_next, blue_tally_next;
  logic     is_white;
  verdict_t pixel_color;

  assign status.last_pixel = last_pixel;

  assign is_white    = (red > white_level) && (green > white_level) && (blue > white_level);
  assign pixel_color = pick_color(tally_t'(red), tally_t'(green), tally_t'(blue));

  always_comb begin
    red_tally_next   = red_tally;
    green_tally_next = green_tally;
    blue_tally_next  = blue_tally;
    if (cmd.clear) begin
      red_tally_next   = '0;
      green_tally_next = '0;
      blue_tally_next  = '0;
    end else if (cmd.count_en && !is_white) begin
      unique case (pixel_color)
        VERDICT_RED:   red_tally_next   = bump(red_tally);
        VERDICT_GREEN: green_tally_next = bump(green_tally);
        default:       blue_tally_next  = bump(blue_tally);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      white_level <= WHITE_RESET;
      red_tally   <= '0;
      green_tally <= '0;
      blue_tally  <= '0;
    end else begin
      if (white_level_we) begin
        white_level <= white_level_wdata;
      end
      red_tally   <= red_tally_next;
      green_tally <= green_tally_next;
      blue_tally  <= blue_tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      verdict     <= pick_color(red_tally, green_tally, blue_tally);
      red_count   <= red_tally;
      green_count <= green_tally;
      blue_count  <= blue_tally;
    end
  end

  a_tally_cap: assert property (@(posedge clk) disable iff (rst)
    (red_tally <= TALLY_CAP) && (green_tally <= TALLY_CAP) && (blue_tally <= TALLY_CAP))
    else $error("tally above its saturation cap");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (red_tally == '0) && (green_tally == '0) && (blue_tally == '0))
    else $error("tallies not cleared after the vote");

endmodule

// ===== rtl/wdcv_ctrl.sv =====
// Controller of the color vote: count and vote states and the result valid flag.
`timescale 1ns / 1ps

module wdcv_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  wdcv_pkg::wdcv_status_t status,
  output wdcv_pkg::wdcv_cmd_t    cmd
);
  import wdcv_pkg::*;

  typedef enum logic [1:0] {
    S_COUNT = 2'b01,
    S_VOTE  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   in_take;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_COUNT);
  assign in_take   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_COUNT: begin
        cmd.count_en = in_take;
        if (in_take && status.last_pixel) begin
          state_next = S_VOTE;
        end
      end
      S_VOTE: begin
        // The tallies now hold the whole window; wait for room in the result register.
        if (slot_free) begin
          cmd.load_out   = 1'b1;
          cmd.clear      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_COUNT;
        end
      end
      default: begin
        state_next = S_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COUNT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> slot_free)
    else $error("pending result overwritten");

  a_vote_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_take && status.last_pixel) |=> (state == S_VOTE) && !in_ready)
    else $error("no vote after the last pixel of a window");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

endmodule
